@@ rtl/snf_pkg.sv @@
`default_nettype none
package snf_pkg;

  // Sizes are taken as powers of two.
  localparam int unsigned MEM_BYTES_DEF    = 65536;
  localparam int unsigned PAGE_BYTES_DEF   = 256;
  localparam int unsigned SECTOR_BYTES_DEF = 4096;

  localparam int unsigned CURSOR_W  = 24;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [7:0] CMD_NONE  = 8'h00;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_RDID  = 8'h90;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'h20;

  localparam logic [7:0] MISO_IDLE = 8'hFF;
  localparam logic [7:0] ERASED    = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_MFR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEV = CFG_IDX_W'(1);

  localparam logic [7:0] MFR_RESET = 8'd239;
  localparam logic [7:0] DEV_RESET = 8'd23;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_READ,
    ACT_PROG,
    ACT_ERASE
  } act_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_PROG_WR,
    ST_ERASE
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_rdata;
    logic prog_write;
    logic sweep_write;
    logic sweep_full;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic clear_last;
    logic erase_last;
    logic out_blocked;
  } ctrl_stat_t;

endpackage
`default_nettype wire

@@ rtl/spi_nor_flash_device_top.sv @@
`default_nettype none
// Channel   Handshake               Payload
// in        in_valid / in_stall     in_op, in_mosi_byte
// out       out_valid / out_stall   out_miso_byte
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each request gives one result. A read byte waits in ST_RD_WAIT for the
// registered RAM read, a program byte with the latch set does its
// read-modify-write in ST_PROG_WR, and a deselect that erases sweeps its
// sector in ST_ERASE a byte at a time, set by the single RAM write port.
// After reset the memory is swept to 0xFF, one byte a cycle over all MEM_BYTES
// bytes, with in_stall high; cfg writes are taken at any time.
// A held result in the output register stalls the next request.
module spi_nor_flash_device_top #(
  parameter int unsigned MEM_BYTES    = snf_pkg::MEM_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = snf_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = snf_pkg::SECTOR_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_mosi_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [7:0]                    out_miso_byte,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [snf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import snf_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  snf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  snf_dp #(
    .MEM_BYTES   (MEM_BYTES),
    .PAGE_BYTES  (PAGE_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_mosi_byte (in_mosi_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_miso_byte(out_miso_byte),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
`default_nettype wire

@@ rtl/snf_ram.sv @@
`default_nettype none
module snf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/snf_ctrl.sv @@
`default_nettype none
module snf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire snf_pkg::ctrl_stat_t stat,
  output snf_pkg::ctrl_cmd_t      cmd
);
  import snf_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign take = (state_r == ST_IDLE) && !stat.out_blocked && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          unique case (stat.act)
            ACT_READ:  state_nxt = ST_RD_WAIT;
            ACT_PROG:  state_nxt = ST_PROG_WR;
            ACT_ERASE: state_nxt = ST_ERASE;
            ACT_NONE:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT: state_nxt = ST_IDLE;
      ST_PROG_WR: state_nxt = ST_IDLE;
      ST_ERASE: begin
        if (stat.erase_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep_write = 1'b1;
        cmd.sweep_full  = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = stat.out_blocked;
        cmd.accept = take;
      end
      ST_RD_WAIT: cmd.load_rdata = 1'b1;
      ST_PROG_WR: cmd.prog_write = 1'b1;
      ST_ERASE:   cmd.sweep_write = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/snf_dp.sv @@
`default_nettype none
module snf_dp #(
  parameter int unsigned MEM_BYTES    = snf_pkg::MEM_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = snf_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = snf_pkg::SECTOR_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_mosi_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [7:0]                    out_miso_byte,
  input  wire logic                          cfg_valid,
  input  wire logic [snf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire snf_pkg::ctrl_cmd_t            cmd,
  output snf_pkg::ctrl_stat_t                stat
);
  import snf_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned PW = $clog2(PAGE_BYTES);
  localparam int unsigned SW = $clog2(SECTOR_BYTES);
  localparam int unsigned EW = (SW < AW) ? SW : AW;
  localparam logic [AW-1:0] EMASK = AW'((64'd1 << EW) - 64'd1);
  localparam logic [2:0] POS_MAX = 3'd5;

  logic [7:0]          cmd_r, cmd_nxt;
  logic [2:0]          pos_r, pos_nxt;
  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic                wel_r, wel_nxt;
  logic [7:0]          mfr_r, dev_r;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_r, out_nxt;
  logic [7:0]          miso;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       prog_addr_r, base_r;
  logic [7:0]          prog_data_r;
  logic [AW-1:0]       addr, addr_inc, addr_page;
  logic [PW-1:0]       off_inc;
  logic [CURSOR_W-1:0] shifted;
  logic [2:0]          pos_inc;
  act_t                act;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;

  assign addr      = cursor_r[AW-1:0];
  assign addr_inc  = addr + 1'b1;
  assign off_inc   = addr[PW-1:0] + 1'b1;
  assign addr_page = {addr[AW-1:PW], off_inc};
  assign shifted   = {cursor_r[CURSOR_W-9:0], in_mosi_byte};
  assign pos_inc   = (pos_r < POS_MAX) ? pos_r + 3'd1 : pos_r;

  // Command decoder: one SPI exchange or a deselect.
  always_comb begin
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    cursor_nxt = cursor_r;
    wel_nxt    = wel_r;
    miso       = MISO_IDLE;
    act        = ACT_NONE;
    if (in_op) begin
      if (cmd_r == CMD_WREN && pos_r >= 3'd1) begin
        wel_nxt = 1'b1;
      end else if ((cmd_r == CMD_PP || cmd_r == CMD_SE) && pos_r >= 3'd4) begin
        if (cmd_r == CMD_SE && wel_r) act = ACT_ERASE;
        wel_nxt = 1'b0;
      end
      cmd_nxt = CMD_NONE;
      pos_nxt = 3'd0;
    end else if (pos_r == 3'd0) begin
      cmd_nxt = in_mosi_byte;
      pos_nxt = 3'd1;
    end else begin
      pos_nxt = pos_inc;
      unique case (cmd_r)
        CMD_RDSR: miso = {6'd0, wel_r, 1'b0};
        CMD_RDID: begin
          if (pos_r == 3'd4) begin
            miso    = mfr_r;
            pos_nxt = 3'd5;
          end else if (pos_r >= 3'd5) begin
            miso    = dev_r;
            pos_nxt = 3'd4;
          end
        end
        CMD_READ, CMD_PP, CMD_SE: begin
          if (pos_r <= 3'd3) begin
            cursor_nxt = (pos_r == 3'd3) ? CURSOR_W'(shifted[AW-1:0]) : shifted;
          end else if (cmd_r == CMD_READ) begin
            act        = ACT_READ;
            cursor_nxt = CURSOR_W'(addr_inc);
          end else if (cmd_r == CMD_PP) begin
            if (wel_r) act = ACT_PROG;
            cursor_nxt = CURSOR_W'(addr_page);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.accept && act != ACT_READ) begin
      out_valid_nxt = 1'b1;
      out_nxt       = miso;
    end else if (cmd.load_rdata) begin
      out_valid_nxt = 1'b1;
      out_nxt       = ram_rdata;
    end
  end

  // Sweep counter serves the power-up clear and the sector erase.
  assign stat.clear_last  = (cnt_r == '1);
  assign stat.erase_last  = ((cnt_r & EMASK) == EMASK);
  assign stat.act         = act;
  assign stat.out_blocked = out_valid_r && out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.sweep_write) begin
      cnt_nxt = (!cmd.sweep_full && stat.erase_last) ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= CMD_NONE;
      pos_r       <= 3'd0;
      cursor_r    <= '0;
      wel_r       <= 1'b0;
      mfr_r       <= MFR_RESET;
      dev_r       <= DEV_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cmd.accept) begin
        cmd_r    <= cmd_nxt;
        pos_r    <= pos_nxt;
        cursor_r <= cursor_nxt;
        wel_r    <= wel_nxt;
      end
      if (cfg_valid) begin
        if (cfg_index == REG_MFR) mfr_r <= cfg_data;
        if (cfg_index == REG_DEV) dev_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.accept) begin
      prog_addr_r <= addr;
      prog_data_r <= in_mosi_byte;
      base_r      <= addr & ~EMASK;
    end
  end

  assign ram_we    = cmd.prog_write || cmd.sweep_write;
  assign ram_wdata = cmd.prog_write ? (ram_rdata & prog_data_r) : ERASED;
  always_comb begin
    priority if (cmd.prog_write) ram_waddr = prog_addr_r;
    else if (cmd.sweep_full)     ram_waddr = cnt_r;
    else                         ram_waddr = base_r | (cnt_r & EMASK);
  end

  snf_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_miso_byte = out_r;

endmodule
`default_nettype wire
